### design/fpbm_pkg.sv
// fpbm_pkg: shared widths, codes, types and the divider step for the
// flash plane/block mapping block. No dependencies.

package fpbm_pkg;

	localparam int IW  = 16;  // index width
	localparam int PLW = 4;   // plane field width
	localparam int BW  = 17;  // plane size / element size register width
	localparam int PW  = 5;   // planes_per_package width
	localparam int DW  = 22;  // widest divisor (plane size * planes)
	localparam int RW  = 23;  // unclipped result width

	localparam int MAX_BLOCKS_DEF = 65536;
	localparam int MAX_PLANES_DEF = 16;

	// one cell per quotient bit, then compute and output stages
	localparam int LATENCY = IW + 2;

	localparam logic [1:0] KIND_CONCAT = 2'd0;
	localparam logic [1:0] KIND_PAIR   = 2'd1;
	localparam logic [1:0] KIND_FULL   = 2'd2;

	localparam logic [1:0] REG_KIND   = 2'd0;
	localparam logic [1:0] REG_BPP    = 2'd1;
	localparam logic [1:0] REG_PLANES = 2'd2;
	localparam logic [1:0] REG_ELEM   = 2'd3;

	localparam logic MODE_TO_BLOCK = 1'b0;
	localparam logic MODE_TO_POS   = 1'b1;

	localparam logic [1:0]    KIND_RST   = KIND_CONCAT;
	localparam logic [BW-1:0] BPP_RST    = BW'(1024);
	localparam logic [PW-1:0] PLANES_RST = PW'(8);
	localparam logic [BW-1:0] ELEM_RST   = BW'(8192);

	typedef struct packed {
		logic [BW-1:0] b;
		logic [PW-1:0] p;
		logic [DW-1:0] pb;
	} fpbm_div_t;

	typedef struct packed {
		logic          vld;
		logic          mode;
		logic [IW-1:0] x;
		logic [IW-1:0] rem_b;
		logic [IW-1:0] rem_p;
		logic [IW-1:0] rem_pb;
		logic [IW-1:0] q_b;
		logic [IW-1:0] q_p;
		logic [IW-1:0] q_pb;
	} fpbm_cell_t;

	typedef struct packed {
		logic [IW-1:0] rem;
		logic          q;
	} fpbm_step_t;

	// one restoring division step; the remainder never exceeds the dividend
	function automatic fpbm_step_t div_step(input logic [IW-1:0] rem, input logic xbit,
			input logic [DW-1:0] d);
		logic [IW:0]   trial;
		logic [DW-1:0] wide;
		fpbm_step_t    r;
		trial = {rem, xbit};
		wide  = DW'(trial);
		if (wide >= d) begin
			r.q   = 1'b1;
			r.rem = IW'(wide - d);
		end else begin
			r.q   = 1'b0;
			r.rem = trial[IW-1:0];
		end
		return r;
	endfunction

endpackage

### design/fpbm_cell.sv
// fpbm_cell: one link of the divider chain; produces one quotient bit for
// each of the three divisors and hands the item on. Uses fpbm_pkg.

module fpbm_cell import fpbm_pkg::*; #(
	parameter int BIT_POS = 0
) (
	input  logic       clk,
	input  logic       arst_n,
	input  fpbm_cell_t din,
	input  fpbm_div_t  div,
	output fpbm_cell_t dout
);

	fpbm_step_t st_b, st_p, st_pb;
	fpbm_cell_t nxt;
	fpbm_cell_t cell_q;

	always_comb begin
		st_b  = div_step(din.rem_b,  din.x[BIT_POS], DW'(div.b));
		st_p  = div_step(din.rem_p,  din.x[BIT_POS], DW'(div.p));
		st_pb = div_step(din.rem_pb, din.x[BIT_POS], div.pb);
		nxt        = din;
		nxt.rem_b  = st_b.rem;
		nxt.rem_p  = st_p.rem;
		nxt.rem_pb = st_pb.rem;
		nxt.q_b    = {din.q_b[IW-2:0],  st_b.q};
		nxt.q_p    = {din.q_p[IW-2:0],  st_p.q};
		nxt.q_pb   = {din.q_pb[IW-2:0], st_pb.q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_q <= '0;
		end else begin
			cell_q <= nxt;
		end
	end

	assign dout = cell_q;

endmodule

### design/fpbm_finish.sv
// fpbm_finish: builds the mapped index and plane from quotients and
// remainders, then range-checks and registers the result. Uses fpbm_pkg.

module fpbm_finish import fpbm_pkg::*; #(
	parameter int MAX_PLANES = MAX_PLANES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  fpbm_cell_t       cin,
	input  fpbm_div_t        div,
	input  logic [1:0]       kind,
	input  logic [BW-1:0]    elem,
	output logic             done,
	output logic [IW-1:0]    mapped_index,
	output logic [PLW-1:0]   plane_of_position,
	output logic             out_of_range,
	output logic             bad_mapping
);

	localparam int PL_MAX = (MAX_PLANES - 1 < 15) ? MAX_PLANES - 1 : 15;

	logic [RW-1:0]  r_pair;
	logic [BW-1:0]  mul_a;
	logic [PW-1:0]  mul_c;
	logic [DW-1:0]  prod;
	logic [IW-1:0]  add_q;
	logic [RW-1:0]  res;
	logic [IW:0]    plane_raw;
	logic [PLW-1:0] plane;
	logic           bad;

	logic           vld_s1;
	logic [RW-1:0]  chk_s1;
	logic           xoor_s1;
	logic [PLW-1:0] plane_s1;
	logic           bad_s1;

	logic           done_q;
	logic [IW-1:0]  mapped_q;
	logic [PLW-1:0] plane_q;
	logic           oor_q;
	logic           bad_q;

	always_comb begin
		r_pair = (cin.q_b[0] ? RW'(div.b) : '0) + RW'(cin.rem_b);
		if (cin.mode == MODE_TO_BLOCK) begin
			mul_a = BW'(cin.rem_b);
			mul_c = div.p;
			add_q = cin.q_b;
		end else begin
			mul_a = div.b;
			mul_c = cin.rem_p[PW-1:0];
			add_q = cin.q_p;
		end
		prod = DW'(mul_a) * DW'(mul_c);

		bad       = 1'b0;
		res       = RW'(cin.x);
		plane_raw = (IW+1)'(cin.q_b);
		case (kind)
			KIND_CONCAT: begin
				res = RW'(cin.x);
			end
			KIND_PAIR: begin
				if (cin.mode == MODE_TO_BLOCK) begin
					res = RW'(cin.x) - r_pair + (RW'(cin.rem_b) << 1) + RW'(cin.q_b[0]);
				end else begin
					res = RW'(cin.x) - r_pair + (cin.x[0] ? RW'(div.b) : '0)
						+ (r_pair >> 1);
					plane_raw = (IW+1)'({cin.q_b[IW-1:1], cin.x[0]});
				end
			end
			KIND_FULL: begin
				res = RW'(prod) + RW'(add_q);
				if (cin.mode == MODE_TO_POS) begin
					plane_raw = (IW+1)'(cin.rem_p) + (IW+1)'(cin.q_pb);
				end
			end
			default: begin
				bad = 1'b1;
			end
		endcase

		if (plane_raw > (IW+1)'(PL_MAX)) begin
			plane = PLW'(PL_MAX);
		end else begin
			plane = plane_raw[PLW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= cin.vld;
		end
	end

	always_ff @(posedge clk) begin
		chk_s1   <= bad ? RW'(cin.x) : res;
		xoor_s1  <= (RW'(cin.x) >= RW'(elem));
		plane_s1 <= bad ? '0 : plane;
		bad_s1   <= bad;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		mapped_q <= bad_s1 ? '0 : chk_s1[IW-1:0];
		plane_q  <= plane_s1;
		oor_q    <= xoor_s1 || (chk_s1 >= RW'(elem)) || (chk_s1 > RW'({IW{1'b1}}));
		bad_q    <= bad_s1;
	end

	assign done              = done_q;
	assign mapped_index      = mapped_q;
	assign plane_of_position = plane_q;
	assign out_of_range      = oor_q;
	assign bad_mapping       = bad_q;

endmodule

### design/flash_plane_block_mapping.sv
// Throughput: one item per cycle; busy stays low, results cannot be stalled.
// The 16-cell divider chain (one quotient bit per cell) plus a compute stage
// and an output register set the latency.
// Reset clears all valid flags and loads the register defaults.
// flash_plane_block_mapping: top level; config registers, divider chain.
// Uses fpbm_pkg, fpbm_cell, fpbm_finish.

module flash_plane_block_mapping import fpbm_pkg::*; #(
	parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
	parameter int MAX_PLANES = MAX_PLANES_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  logic           mode,
	input  logic [IW-1:0]  index_in,
	input  logic           wr_en,
	input  logic [1:0]     wr_index,
	input  logic [BW-1:0]  wr_data,
	output logic           done,
	output logic [IW-1:0]  mapped_index,
	output logic [PLW-1:0] plane_of_position,
	output logic           out_of_range,
	output logic           bad_mapping
);

	logic [1:0]    kind_q;
	logic [BW-1:0] bpp_q;
	logic [PW-1:0] planes_q;
	logic [BW-1:0] elem_q;

	logic [BW-1:0] b_eff;
	logic [PW-1:0] p_eff;
	logic [BW-1:0] e_eff;
	fpbm_div_t     div;
	fpbm_cell_t    chain [IW+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q   <= KIND_RST;
			bpp_q    <= BPP_RST;
			planes_q <= PLANES_RST;
			elem_q   <= ELEM_RST;
		end else if (wr_en) begin
			case (wr_index)
				REG_KIND:   kind_q   <= wr_data[1:0];
				REG_BPP:    bpp_q    <= wr_data;
				REG_PLANES: planes_q <= wr_data[PW-1:0];
				REG_ELEM:   elem_q   <= wr_data;
				default:    kind_q   <= kind_q;
			endcase
		end
	end

	always_comb begin
		if (bpp_q == '0) begin
			b_eff = BW'(1);
		end else if (32'(bpp_q) > 32'(MAX_BLOCKS)) begin
			b_eff = BW'(MAX_BLOCKS);
		end else begin
			b_eff = bpp_q;
		end
		if (planes_q == '0) begin
			p_eff = PW'(1);
		end else if (32'(planes_q) > 32'(MAX_PLANES)) begin
			p_eff = PW'(MAX_PLANES);
		end else begin
			p_eff = planes_q;
		end
		if (32'(elem_q) > 32'(MAX_BLOCKS)) begin
			e_eff = BW'(MAX_BLOCKS);
		end else begin
			e_eff = elem_q;
		end
		div.b  = b_eff;
		div.p  = p_eff;
		div.pb = DW'(b_eff) * DW'(p_eff);
	end

	assign busy = 1'b0;

	always_comb begin
		chain[0]      = '0;
		chain[0].vld  = start & ~busy;
		chain[0].mode = mode;
		chain[0].x    = index_in;
	end

	for (genvar i = 0; i < IW; i++) begin : g_cell
		fpbm_cell #(
			.BIT_POS(IW - 1 - i)
		) u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.din   (chain[i]),
			.div   (div),
			.dout  (chain[i+1])
		);
	end

	fpbm_finish #(
		.MAX_PLANES(MAX_PLANES)
	) u_finish (
		.clk              (clk),
		.arst_n           (arst_n),
		.cin              (chain[IW]),
		.div              (div),
		.kind             (kind_q),
		.elem             (e_eff),
		.done             (done),
		.mapped_index     (mapped_index),
		.plane_of_position(plane_of_position),
		.out_of_range     (out_of_range),
		.bad_mapping      (bad_mapping)
	);

endmodule

### design/fpbm_checker.sv
// fpbm_checker: port-level checks of latency and unknown-layout results,
// bound to flash_plane_block_mapping. Uses fpbm_pkg.

module fpbm_checker import fpbm_pkg::*; (
	input logic           clk,
	input logic           arst_n,
	input logic           start,
	input logic           busy,
	input logic           done,
	input logic [IW-1:0]  mapped_index,
	input logic [PLW-1:0] plane_of_position,
	input logic           bad_mapping
);

	a_item_done: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##LATENCY done)
		else $error("accepted item produced no result");

	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result without a matching item");

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && bad_mapping |-> mapped_index == '0 && plane_of_position == '0)
		else $error("unknown layout result carries data");

endmodule

bind flash_plane_block_mapping fpbm_checker u_fpbm_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.start            (start),
	.busy             (busy),
	.done             (done),
	.mapped_index     (mapped_index),
	.plane_of_position(plane_of_position),
	.bad_mapping      (bad_mapping)
);
